@@ rtl/core/ctee_pkg.sv @@
// ----------------------------------------------------------------------------
// ctee_pkg: shared constants, types and microcode for the cosine core
// Field widths, register indexes, fixed-point constants and the control
// program run by the sequencer in cosine_taylor_eps_core.
// ----------------------------------------------------------------------------
package ctee_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_TERMS     = 32;
   localparam int DEF_ACC_FRAC_BITS = 28;

   // payload fields
   localparam int ANGLE_W    = 16;
   localparam int ANGLE_FRAC = 13;
   localparam int COSINE_W   = 16;
   localparam int COS_FRAC   = 14;
   localparam int TERMS_W    = 6;
   localparam int TERMS_CAP  = 63;

   // configuration registers
   localparam int EPS_W      = 14;
   localparam int LIMIT_W    = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_EPS_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LIMIT    = 1'b1;

   localparam logic [EPS_W-1:0]   EPS_RESET   = 14'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   // datapath slicing
   localparam int MUL_CHUNK    = 16;   // multiplier B slice per pass
   localparam int DIV_BITS     = 4;    // quotient bits per divide pass
   localparam int SCALE_FRAC   = 64;
   localparam int SCALE_CHUNKS = SCALE_FRAC / MUL_CHUNK;

   // pi/4 and sqrt(2)/2, both Q0.64
   localparam logic [63:0] PI4_Q64        = 64'hC90FDAA22168C235;
   localparam logic [63:0] HALF_SQRT2_Q64 = 64'hB504F333F9DE6484;

   localparam logic [COS_FRAC:0] COS_ONE = 15'd16384;

   // ---- microcode ----
   typedef enum logic [3:0] {
      OP_LOAD,     // take the angle, form d = x - pi/4
      OP_ABS,      // |d|, sign of d, seed term and sum
      OP_ADD,      // sum += signed term
      OP_TEST,     // stop checks, advance term index
      OP_TSETUP,   // multiplier: term * |d|
      OP_MUL,      // one multiplier pass
      OP_DSETUP,   // divider: product / k
      OP_DIV,      // one divider pass
      OP_MLOAD,    // quotient becomes the new term
      OP_SSETUP,   // multiplier: |sum| * sqrt(2)/2
      OP_ROUND,    // round, saturate, load result register
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_START,  // no input transfer this cycle
      CND_EXIT,      // series finished
      CND_LOOP,      // pass counter not yet zero
      CND_BUSY       // result register still occupied
   } cond_type;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UA_WAIT   = 4'd0;
   localparam upc_type UA_ABS    = 4'd1;
   localparam upc_type UA_ADD    = 4'd2;
   localparam upc_type UA_TEST   = 4'd3;
   localparam upc_type UA_TSETUP = 4'd4;
   localparam upc_type UA_TMUL   = 4'd5;
   localparam upc_type UA_DSETUP = 4'd6;
   localparam upc_type UA_DIV    = 4'd7;
   localparam upc_type UA_MLOAD  = 4'd8;
   localparam upc_type UA_SSETUP = 4'd9;
   localparam upc_type UA_SMUL   = 4'd10;
   localparam upc_type UA_ROUND  = 4'd11;
   localparam upc_type UA_RET    = 4'd12;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;   // taken when cond holds, else fall through
   } uword_type;

   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      case (addr)
         UA_WAIT:   w = '{OP_LOAD,   CND_NO_START, UA_WAIT};
         UA_ABS:    w = '{OP_ABS,    CND_NEVER,    UA_WAIT};
         UA_ADD:    w = '{OP_ADD,    CND_NEVER,    UA_WAIT};
         UA_TEST:   w = '{OP_TEST,   CND_EXIT,     UA_SSETUP};
         UA_TSETUP: w = '{OP_TSETUP, CND_NEVER,    UA_WAIT};
         UA_TMUL:   w = '{OP_MUL,    CND_LOOP,     UA_TMUL};
         UA_DSETUP: w = '{OP_DSETUP, CND_NEVER,    UA_WAIT};
         UA_DIV:    w = '{OP_DIV,    CND_LOOP,     UA_DIV};
         UA_MLOAD:  w = '{OP_MLOAD,  CND_ALWAYS,   UA_ADD};
         UA_SSETUP: w = '{OP_SSETUP, CND_NEVER,    UA_WAIT};
         UA_SMUL:   w = '{OP_MUL,    CND_LOOP,     UA_SMUL};
         UA_ROUND:  w = '{OP_ROUND,  CND_BUSY,     UA_ROUND};
         UA_RET:    w = '{OP_NOP,    CND_ALWAYS,   UA_WAIT};
         default:   w = '{OP_NOP,    CND_ALWAYS,   UA_WAIT};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/ctee_req_if.sv @@
// ----------------------------------------------------------------------------
// ctee_req_if: angle request channel
// valid/ready handshake carrying one signed Q2.13 angle per transfer.
// ----------------------------------------------------------------------------
interface ctee_req_if;
   import ctee_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

@@ rtl/core/ctee_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ctee_rsp_if: cosine response channel
// valid/ready handshake carrying the Q1.14 cosine and series status.
// ----------------------------------------------------------------------------
interface ctee_rsp_if;
   import ctee_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [COSINE_W-1:0] cosine;
   logic [TERMS_W-1:0]         terms_used;
   logic                       limit_hit;

   modport source (output valid, output cosine, output terms_used, output limit_hit,
                   input ready);
   modport sink   (input valid, input cosine, input terms_used, input limit_hit,
                   output ready);
endinterface

@@ rtl/core/cosine_taylor_eps_core.sv @@
// ----------------------------------------------------------------------------
// cosine_taylor_eps_core: cosine by Taylor series about pi/4
// Input is taken only while the sequencer waits, one angle at a time;
//   each non-final term runs a multiply by |d| and a divide by k.
// The result register lets a new angle start while the previous result
//   waits; rounding stalls until that result has been taken.
// Reset: synchronous; clears sequencer and result valid, eps 1, limit 32.
// ----------------------------------------------------------------------------
module cosine_taylor_eps_core #(
   parameter int MAX_TERMS     = ctee_pkg::DEF_MAX_TERMS,
   parameter int ACC_FRAC_BITS = ctee_pkg::DEF_ACC_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   ctee_req_if.sink                           req_ch,
   ctee_rsp_if.source                         rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [ctee_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctee_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ctee_pkg::*;

   // ---------------------------------------------------------------------
   // Formats. F fractional bits throughout the series.
   //   d       : signed, |d| < 4.8      -> F+4 bits
   //   term m  : |d|^k/k! < 22          -> F+5 bits
   //   m*|d|>>F: < 106 (divide input)   -> F+7 bits
   //   sum f   : |f| < e^4.8 < 128      -> F+8 bits signed
   // ---------------------------------------------------------------------
   localparam int F     = ACC_FRAC_BITS;
   localparam int DSW   = F + 4;
   localparam int DMW   = F + 3;
   localparam int MW    = F + 5;
   localparam int DVW   = F + 7;
   localparam int FW    = F + 8;
   localparam int AW    = FW;                 // multiplier A operand
   localparam int ACW   = AW + MUL_CHUNK;     // multiplier accumulator

   // |d| is left-aligned in its slices so the retained accumulator still
   // carries every bit of the truncated product.
   localparam int ND         = (DMW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int BW         = (ND * MUL_CHUNK > SCALE_FRAC) ? ND * MUL_CHUNK : SCALE_FRAC;
   localparam int B_ALIGN    = ND * MUL_CHUNK - DMW;
   localparam int TERM_SHIFT = F + B_ALIGN - MUL_CHUNK * (ND - 1);
   localparam int SCALE_SHIFT = F + SCALE_FRAC - (COS_FRAC + 1)
                                - MUL_CHUNK * (SCALE_CHUNKS - 1);
   localparam int QW         = ACW - SCALE_SHIFT;

   localparam int NDIV  = (DVW + DIV_BITS - 1) / DIV_BITS;
   localparam int DVP   = NDIV * DIV_BITS;

   localparam int LOOP_MAX = (NDIV > ND) ?
                             ((NDIV > SCALE_CHUNKS) ? NDIV : SCALE_CHUNKS) :
                             ((ND > SCALE_CHUNKS) ? ND : SCALE_CHUNKS);
   localparam int LCW      = $clog2(LOOP_MAX);

   localparam int LIM_CAP  = (MAX_TERMS < TERMS_CAP) ? MAX_TERMS : TERMS_CAP;

   // pi/4 rounded to nearest at F fractional bits
   localparam logic [DSW-1:0] PI4 = DSW'(((PI4_Q64 >> (63 - F)) + 64'd1) >> 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   upc_type                  pc_ff, pc_in;
   logic [EPS_W-1:0]         eps_ff, eps_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;

   logic signed [DSW-1:0]    d_ff, d_in;
   logic                     dneg_ff, dneg_in;
   logic [DMW-1:0]           dm_ff, dm_in;
   logic [MW-1:0]            m_ff, m_in;
   logic signed [FW-1:0]     f_ff, f_in;
   logic [TERMS_W-1:0]       k_ff, k_in;
   logic                     hit_ff, hit_in;

   logic [AW-1:0]            mul_a_ff, mul_a_in;
   logic [BW-1:0]            mul_b_ff, mul_b_in;
   logic [ACW-1:0]           acc_ff, acc_in;
   logic [DVP-1:0]           div_ff, div_in;
   logic [TERMS_W-1:0]       rem_ff, rem_in;
   logic [LCW-1:0]           loop_ff, loop_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COSINE_W-1:0] rsp_cosine_ff, rsp_cosine_in;
   logic [TERMS_W-1:0]       rsp_terms_ff, rsp_terms_in;
   logic                     rsp_hit_ff, rsp_hit_in;

   // ---------------------------------------------------------------------
   // Decode and status
   // ---------------------------------------------------------------------
   uword_type                uw;
   logic                     req_fire;
   logic                     eps_met;
   logic                     last_term;
   logic                     term_neg;
   logic                     out_busy;
   logic                     take;
   logic [LIMIT_W:0]         lim_raw;
   logic [LIMIT_W:0]         lim;
   logic [MW-1:0]            eps_ext;
   logic [ACW-1:0]           mul_pp;
   logic [DSW-1:0]           d_negated;
   logic [FW-1:0]            f_negated;
   logic [FW-1:0]            f_mag;
   logic signed [FW-1:0]     m_ext;
   logic [QW:0]              rnd_full;
   logic [COS_FRAC:0]        cos_mag;
   logic [COSINE_W-1:0]      cos_pos;

   // divider pass
   logic [DVP-1:0]           dq;
   logic [TERMS_W-1:0]       dr;
   logic [TERMS_W:0]         dt;

   assign uw       = ucode_rom(pc_ff);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_busy = rsp_valid_ff && !rsp_ch.ready;

   // term limit: zero acts as one, then clamp
   assign lim_raw   = (limit_ff == '0) ? (LIMIT_W + 1)'(1) : {1'b0, limit_ff};
   assign lim       = (lim_raw > (LIMIT_W + 1)'(LIM_CAP)) ? (LIMIT_W + 1)'(LIM_CAP) : lim_raw;
   assign last_term = ({1'b0, k_ff} + (LIMIT_W + 1)'(1)) >= lim;

   assign eps_ext = MW'({eps_ff, {(F - EPS_W){1'b0}}});
   assign eps_met = m_ff < eps_ext;

   // sign pattern +,-,-,+ over k mod 4, flipped on odd k for negative d
   assign term_neg = ((k_ff[1:0] == 2'd1) || (k_ff[1:0] == 2'd2)) ^ (dneg_ff & k_ff[0]);

   assign m_ext     = $signed({{(FW - MW){1'b0}}, m_ff});
   assign d_negated = -d_ff;
   assign f_negated = -f_ff;
   assign f_mag     = f_ff[FW-1] ? f_negated : f_ff;

   // shared multiplier: A times one 16-bit slice of B
   assign mul_pp = mul_a_ff * mul_b_ff[MUL_CHUNK-1:0];

   // round half away from zero to Q1.14 and saturate at one
   assign rnd_full = {1'b0, acc_ff[ACW-1:SCALE_SHIFT]} + (QW + 1)'(1);
   assign cos_mag  = (rnd_full[QW:1] > QW'(COS_ONE)) ? COS_ONE : rnd_full[COS_FRAC+1:1];
   assign cos_pos  = {1'b0, cos_mag};

   // restoring divide by k, DIV_BITS quotient bits per pass
   always_comb begin
      dq = div_ff;
      dr = rem_ff;
      dt = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         dt = {dr, dq[DVP-1]};
         dq = {dq[DVP-2:0], 1'b0};
         if (dt >= {1'b0, k_ff}) begin
            dr    = TERMS_W'(dt - {1'b0, k_ff});
            dq[0] = 1'b1;
         end else begin
            dr = dt[TERMS_W-1:0];
         end
      end
   end

   // branch condition
   always_comb begin
      case (uw.cond)
         CND_NEVER:    take = 1'b0;
         CND_ALWAYS:   take = 1'b1;
         CND_NO_START: take = !req_fire;
         CND_EXIT:     take = eps_met || last_term;
         CND_LOOP:     take = loop_ff != '0;
         CND_BUSY:     take = out_busy;
         default:      take = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      pc_in         = take ? uw.target : pc_ff + upc_type'(1);
      eps_in        = eps_ff;
      limit_in      = limit_ff;
      d_in          = d_ff;
      dneg_in       = dneg_ff;
      dm_in         = dm_ff;
      m_in          = m_ff;
      f_in          = f_ff;
      k_in          = k_ff;
      hit_in        = hit_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      acc_in        = acc_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      loop_in       = loop_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cosine_in = rsp_cosine_ff;
      rsp_terms_in  = rsp_terms_ff;
      rsp_hit_in    = rsp_hit_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_EPS_THRESHOLD: eps_in   = csr_wdata[EPS_W-1:0];
            CSR_TERM_LIMIT:    limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (uw.op)
         OP_LOAD: begin
            if (req_fire) begin
               d_in = $signed({req_ch.angle[ANGLE_W-1], req_ch.angle,
                               {(F - ANGLE_FRAC){1'b0}}}) - $signed(PI4);
            end
         end
         OP_ABS: begin
            dneg_in = d_ff[DSW-1];
            dm_in   = d_ff[DSW-1] ? d_negated[DMW-1:0] : d_ff[DMW-1:0];
            m_in    = MW'(1) << F;
            f_in    = '0;
            k_in    = '0;
         end
         OP_ADD: begin
            f_in = term_neg ? f_ff - m_ext : f_ff + m_ext;
         end
         OP_TEST: begin
            // terms_used ends up equal to k after this step
            k_in   = k_ff + TERMS_W'(1);
            hit_in = !eps_met;
         end
         OP_TSETUP: begin
            mul_a_in = AW'(m_ff);
            mul_b_in = BW'(dm_ff) << B_ALIGN;
            acc_in   = '0;
            loop_in  = LCW'(ND - 1);
         end
         OP_MUL: begin
            // low slice first; retired bits fall off the bottom
            acc_in   = (acc_ff >> MUL_CHUNK) + mul_pp;
            mul_b_in = mul_b_ff >> MUL_CHUNK;
            loop_in  = loop_ff - LCW'(1);
         end
         OP_DSETUP: begin
            div_in  = DVP'(acc_ff[TERM_SHIFT +: DVW]);
            rem_in  = '0;
            loop_in = LCW'(NDIV - 1);
         end
         OP_DIV: begin
            div_in  = dq;
            rem_in  = dr;
            loop_in = loop_ff - LCW'(1);
         end
         OP_MLOAD: begin
            m_in = div_ff[MW-1:0];
         end
         OP_SSETUP: begin
            mul_a_in = f_mag;
            mul_b_in = BW'(HALF_SQRT2_Q64);
            acc_in   = '0;
            loop_in  = LCW'(SCALE_CHUNKS - 1);
         end
         OP_ROUND: begin
            if (!out_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_cosine_in = f_ff[FW-1] ? -$signed(cos_pos) : $signed(cos_pos);
               rsp_terms_in  = k_ff;
               rsp_hit_in    = hit_ff;
            end
         end
         OP_NOP: ;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UA_WAIT;
         eps_ff       <= EPS_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         eps_ff       <= eps_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      d_ff          <= d_in;
      dneg_ff       <= dneg_in;
      dm_ff         <= dm_in;
      m_ff          <= m_in;
      f_ff          <= f_in;
      k_ff          <= k_in;
      hit_ff        <= hit_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      acc_ff        <= acc_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      loop_ff       <= loop_in;
      rsp_cosine_ff <= rsp_cosine_in;
      rsp_terms_ff  <= rsp_terms_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_ch.ready      = (pc_ff == UA_WAIT);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cosine     = rsp_cosine_ff;
   assign rsp_ch.terms_used = rsp_terms_ff;
   assign rsp_ch.limit_hit  = rsp_hit_ff;

endmodule
